// File: hw/rtl/tksel_pkg.sv
// Shared types, constants and the ranking function for the top-k score selector.
`default_nettype none

package tksel_pkg;

   // Number of cells in the insertion and drain chains.
   localparam int MAX_KEEP = 16;

   localparam int ID_W    = 32;
   localparam int SCORE_W = 32;
   localparam int COUNT_W = 5;
   localparam int CSR_IDX_W = 1;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_KEEP_COUNT  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HIGHER_WINS = 1'd1;

   typedef struct packed {
      logic [ID_W-1:0]           id;
      logic signed [SCORE_W-1:0] score;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } slot_type;

   // Per-cycle control shared by every insertion cell.
   typedef struct packed {
      logic accept;
      logic flush;
      logic higher_wins;
   } cell_ctrl_type;

   // True when candidate a ranks strictly before candidate b.
   function automatic logic ranks_before(entry_type a, entry_type b, logic higher_wins);
      logic res;
      if (a.score == b.score) begin
         res = (a.id < b.id);
      end else if (higher_wins) begin
         res = ($signed(a.score) > $signed(b.score));
      end else begin
         res = ($signed(a.score) < $signed(b.score));
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tksel_cell.sv
// One cell of the sorted insertion chain: holds one kept candidate.
`default_nettype none

module tksel_cell
   import tksel_pkg::*;
(
   input  wire           clock,
   input  wire           reset,
   input  cell_ctrl_type ctrl,
   input  wire           in_range,
   input  entry_type     cand,
   input  wire           left_before,
   input  slot_type      left_slot,
   output logic          goes_first,
   output slot_type      slot,
   output slot_type      nxt
);

   logic      valid_ff;
   logic      valid_in;
   entry_type entry_ff;
   logic      eff_valid;

   // An entry beyond the current count is treated as empty.
   assign eff_valid = valid_ff && in_range;

   // The newcomer goes before an empty slot or a worse entry.
   assign goes_first = !eff_valid || ranks_before(cand, entry_ff, ctrl.higher_wins);

   assign slot.valid = eff_valid;
   assign slot.entry = entry_ff;

   // Keep, take the newcomer, or take the left neighbour's entry as it shifts right.
   always_comb begin
      nxt.valid = eff_valid;
      nxt.entry = entry_ff;
      if (!in_range) begin
         nxt.valid = 1'b0;
      end else if (goes_first && left_before) begin
         nxt = left_slot;
      end else if (goes_first) begin
         nxt.valid = 1'b1;
         nxt.entry = cand;
      end
   end

   // A query end empties the cell once its contents have been handed to the drain.
   always_comb begin
      valid_in = valid_ff;
      if (ctrl.flush) begin
         valid_in = 1'b0;
      end else if (ctrl.accept) begin
         valid_in = nxt.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         entry_ff <= nxt.entry;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/tksel_drain_cell.sv
// One cell of the output chain that shifts a finished query's results out best first.
`default_nettype none

module tksel_drain_cell
   import tksel_pkg::*;
(
   input  wire      clock,
   input  wire      reset,
   input  wire      load,
   input  wire      shift,
   input  slot_type load_slot,
   input  slot_type right_slot,
   output slot_type slot
);

   logic      valid_ff;
   logic      valid_in;
   entry_type entry_ff;
   entry_type entry_in;

   assign slot.valid = valid_ff;
   assign slot.entry = entry_ff;

   // A load takes the whole sorted list; otherwise each beat taken moves it one cell on.
   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (load) begin
         valid_in = load_slot.valid;
         entry_in = load_slot.entry;
      end else if (shift) begin
         valid_in = right_slot.valid;
         entry_in = right_slot.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

// File: hw/rtl/top_k_score_selector_top.sv
// Top level of the streaming top-k score selector.
`default_nettype none

// Takes one (id, score) candidate per clock and keeps the best keep_count of the current
// query in a chain of MAX_KEEP sorted cells; each cell compares the newcomer with its own
// entry in parallel, so insertion never stalls the stream. The beat marked query_end moves
// the sorted list into a separate drain chain in the same cycle, and results then leave one
// per clock while rsp_ready is high, best first, from the cycle after that beat, with
// rsp_run_last on the final one. The next query streams in while the drain empties.
// A query_end beat waits only while an earlier run still has results in the drain other than a
// final beat being taken that cycle. With keep_count at zero a query gives no results.
// The user must write configuration only while the block is idle; it is not enforced.
module top_k_score_selector_top
   import tksel_pkg::*;
(
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  wire  [ID_W-1:0]           req_cand_id,
   input  wire  signed [SCORE_W-1:0] req_cand_score,
   input  wire                       req_query_end,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output logic [ID_W-1:0]           rsp_best_id,
   output logic signed [SCORE_W-1:0] rsp_best_score,
   output logic                      rsp_run_last,
   input  wire                       csr_wr_en,
   input  wire  [CSR_IDX_W-1:0]      csr_index,
   input  wire  [COUNT_W-1:0]        csr_wdata
);

   logic [COUNT_W-1:0] keep_count_ff;
   logic               higher_wins_ff;

   cell_ctrl_type ctrl;
   entry_type     cand;
   logic          in_accept;
   logic          drain_free;
   logic          shift;

   logic [MAX_KEEP-1:0] in_range;
   logic [MAX_KEEP:0]   before_chain;
   slot_type            cell_slot [MAX_KEEP+1];
   slot_type            cell_nxt  [MAX_KEEP];
   slot_type            drain_slot [MAX_KEEP+1];

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         keep_count_ff  <= COUNT_W'(16);
         higher_wins_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_KEEP_COUNT:  keep_count_ff  <= csr_wdata;
            REG_HIGHER_WINS: higher_wins_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // The drain can take a new list when empty or when its final beat leaves now.
   assign drain_free = !drain_slot[0].valid || (rsp_ready && !drain_slot[1].valid);
   assign req_ready  = !req_query_end || drain_free;
   assign in_accept  = req_valid && req_ready;
   assign shift      = rsp_valid && rsp_ready;

   assign ctrl.accept      = in_accept;
   assign ctrl.flush       = in_accept && req_query_end;
   assign ctrl.higher_wins = higher_wins_ff;

   assign cand.id    = req_cand_id;
   assign cand.score = req_cand_score;

   // The left edge of the chain never shifts anything in.
   assign before_chain[0] = 1'b0;
   assign cell_slot[0]    = '0;
   assign drain_slot[MAX_KEEP] = '0;

   for (genvar g = 0; g < MAX_KEEP; g++) begin : g_chain
      // A cell beyond the effective count holds nothing.
      assign in_range[g] = (32'(g) < 32'(keep_count_ff));

      tksel_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .in_range    (in_range[g]),
         .cand        (cand),
         .left_before (before_chain[g]),
         .left_slot   (cell_slot[g]),
         .goes_first  (before_chain[g+1]),
         .slot        (cell_slot[g+1]),
         .nxt         (cell_nxt[g])
      );

      tksel_drain_cell u_drain (
         .clock      (clock),
         .reset      (reset),
         .load       (ctrl.flush),
         .shift      (shift),
         .load_slot  (cell_nxt[g]),
         .right_slot (drain_slot[g+1]),
         .slot       (drain_slot[g])
      );
   end

   // Result beat comes from the head of the drain chain.
   assign rsp_valid      = drain_slot[0].valid;
   assign rsp_best_id    = drain_slot[0].entry.id;
   assign rsp_best_score = drain_slot[0].entry.score;
   assign rsp_run_last   = !drain_slot[1].valid;

endmodule

`default_nettype wire

// File: hw/rtl/tksel_checker.sv
// Port-level checks for the top-k score selector, bound to its top level.
`default_nettype none

module tksel_checker
   import tksel_pkg::*;
(
   input wire                       clock,
   input wire                       reset,
   input wire                       req_valid,
   input wire                       req_ready,
   input wire                       req_query_end,
   input wire                       rsp_valid,
   input wire                       rsp_ready,
   input wire [ID_W-1:0]            rsp_best_id,
   input wire signed [SCORE_W-1:0]  rsp_best_score,
   input wire                       rsp_run_last
);

   // A stalled result beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_best_id)
         && $stable(rsp_best_score) && $stable(rsp_run_last))
      else $error("stalled result beat changed");

   // A run continues until its final beat has been taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_run_last |=> rsp_valid)
      else $error("run stopped before its final beat");

   // Candidates that do not close a query are never held back.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_query_end |-> req_ready)
      else $error("mid-query candidate stalled");

   // With no results pending, a query end is always taken.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with an empty drain");

endmodule

bind top_k_score_selector_top tksel_checker u_tksel_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_query_end  (req_query_end),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_best_id    (rsp_best_id),
   .rsp_best_score (rsp_best_score),
   .rsp_run_last   (rsp_run_last)
);

`default_nettype wire

// File: tb/tb_top_k_score_selector_top.sv
// Self-checking testbench for the top-k score selector: directed table, random queries, scoreboard.
module tb_top_k_score_selector_top
   import tksel_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET   = 480;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 30;
   localparam int PLAN_ROWS     = 24;

   // Where a directed row takes its expectation from.
   typedef enum logic [1:0] {CHECK_PREDICT, CHECK_SINGLE, CHECK_EMPTY} check_kind_type;

   typedef struct packed {
      logic                      set_cfg;
      logic [COUNT_W-1:0]        keep;
      logic                      higher;
      logic [ID_W-1:0]           id;
      logic signed [SCORE_W-1:0] score;
      logic                      qend;
      check_kind_type            check;
      logic [ID_W-1:0]           exp_id;
      logic signed [SCORE_W-1:0] exp_score;
   } plan_row_type;

   typedef struct {
      logic [ID_W-1:0]           id;
      logic signed [SCORE_W-1:0] score;
      logic                      run_end;
   } best_entry_type;

   // Directed stimulus: single-candidate queries at the field extremes, ties and duplicates,
   // a zero count, a count of one, a count above the chain depth, overflow of a short list,
   // and a count lowered while a query is open.
   localparam plan_row_type DIRECTED_PLAN [PLAN_ROWS] = '{
      '{0, 0,  0, 0,            0,            1, CHECK_SINGLE,  0,            0},
      '{0, 0,  0, 'hFFFF_FFFF,  'h7FFF_FFFF,  1, CHECK_SINGLE,  'hFFFF_FFFF,  'h7FFF_FFFF},
      '{0, 0,  0, 'h5A5A_5A5A,  'h8000_0000,  1, CHECK_SINGLE,  'h5A5A_5A5A,  'h8000_0000},
      '{0, 0,  0, 5,            10,           0, CHECK_PREDICT, 0,            0},
      '{0, 0,  0, 3,            10,           0, CHECK_PREDICT, 0,            0},
      '{0, 0,  0, 9,            -5,           0, CHECK_PREDICT, 0,            0},
      '{0, 0,  0, 3,            10,           0, CHECK_PREDICT, 0,            0},
      '{0, 0,  0, 7,            'h8000_0000,  1, CHECK_PREDICT, 0,            0},
      '{1, 0,  0, 1,            1,            0, CHECK_PREDICT, 0,            0},
      '{0, 0,  0, 2,            2,            1, CHECK_EMPTY,   0,            0},
      '{1, 1,  1, 10,           100,          0, CHECK_PREDICT, 0,            0},
      '{0, 0,  0, 11,           200,          0, CHECK_PREDICT, 0,            0},
      '{0, 0,  0, 12,           200,          1, CHECK_PREDICT, 0,            0},
      '{1, 31, 1, 1,            'h7FFF_FFFF,  0, CHECK_PREDICT, 0,            0},
      '{0, 0,  0, 2,            'h8000_0000,  0, CHECK_PREDICT, 0,            0},
      '{0, 0,  0, 0,            -1,           1, CHECK_PREDICT, 0,            0},
      '{1, 2,  0, 4,            3,            0, CHECK_PREDICT, 0,            0},
      '{0, 0,  0, 5,            1,            0, CHECK_PREDICT, 0,            0},
      '{0, 0,  0, 6,            2,            0, CHECK_PREDICT, 0,            0},
      '{0, 0,  0, 7,            2,            1, CHECK_PREDICT, 0,            0},
      '{1, 16, 0, 1,            5,            0, CHECK_PREDICT, 0,            0},
      '{0, 0,  0, 2,            4,            0, CHECK_PREDICT, 0,            0},
      '{0, 0,  0, 3,            3,            0, CHECK_PREDICT, 0,            0},
      '{1, 1,  0, 4,            6,            1, CHECK_PREDICT, 0,            0}
   };

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [ID_W-1:0]           req_cand_id;
   logic signed [SCORE_W-1:0] req_cand_score;
   logic                      req_query_end;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [ID_W-1:0]           rsp_best_id;
   logic signed [SCORE_W-1:0] rsp_best_score;
   logic                      rsp_run_last;
   logic                      csr_wr_en;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [COUNT_W-1:0]        csr_wdata;

   // Shadow of the selection state and of the registers.
   logic [ID_W-1:0]           sel_ids [MAX_KEEP];
   logic signed [SCORE_W-1:0] sel_scores [MAX_KEEP];
   int                        sel_fill;
   logic [COUNT_W-1:0]        cfg_keep;
   logic                      cfg_higher;

   best_entry_type pending_best[$];
   best_entry_type fresh_run[$];
   int             mismatches = 0;
   int             items_sent = 0;
   bit             calm_sender = 1'b0;

   top_k_score_selector_top u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cand_id    (req_cand_id),
      .req_cand_score (req_cand_score),
      .req_query_end  (req_query_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_best_id    (rsp_best_id),
      .rsp_best_score (rsp_best_score),
      .rsp_run_last   (rsp_run_last),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      mismatches++;
   endtask

   // Strict ranking: better score first, lower id first on equal scores.
   function automatic bit ranks_ahead(input logic [ID_W-1:0] id_a,
                                      input logic signed [SCORE_W-1:0] score_a,
                                      input logic [ID_W-1:0] id_b,
                                      input logic signed [SCORE_W-1:0] score_b);
      if (score_a == score_b) begin
         return id_a < id_b;
      end
      return cfg_higher ? (score_a > score_b) : (score_a < score_b);
   endfunction

   // Inserts one candidate into the shadow list; on the query end the sorted run is
   // left in fresh_run and the list is emptied.
   function automatic void rank_candidate(input logic [ID_W-1:0] id,
                                          input logic signed [SCORE_W-1:0] score,
                                          input logic qend);
      int k;
      int pos;
      int top;
      fresh_run.delete();
      k = (int'(cfg_keep) > MAX_KEEP) ? MAX_KEEP : int'(cfg_keep);
      // A count lowered mid-query drops the worst entries first.
      if (sel_fill > k) begin
         sel_fill = k;
      end
      if (k > 0) begin
         pos = 0;
         while (pos < sel_fill && !ranks_ahead(id, score, sel_ids[pos], sel_scores[pos])) begin
            pos++;
         end
         if (sel_fill < k || pos < sel_fill) begin
            top = (sel_fill < k) ? sel_fill : k - 1;
            for (int i = top; i > pos; i--) begin
               sel_ids[i]    = sel_ids[i-1];
               sel_scores[i] = sel_scores[i-1];
            end
            sel_ids[pos]    = id;
            sel_scores[pos] = score;
            if (sel_fill < k) begin
               sel_fill++;
            end
         end
      end
      if (qend) begin
         for (int i = 0; i < sel_fill; i++) begin
            fresh_run = {fresh_run,
                         best_entry_type'{sel_ids[i], sel_scores[i], (i + 1 == sel_fill)}};
         end
         sel_fill = 0;
      end
   endfunction

   // Idle length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [COUNT_W-1:0] pick_keep();
      int r;
      r = $urandom_range(0, 19);
      if (r < 2) begin
         return '0;
      end else if (r < 4) begin
         return COUNT_W'($urandom_range(17, 31));
      end else if (r < 7) begin
         return COUNT_W'(MAX_KEEP);
      end
      return COUNT_W'($urandom_range(1, 8));
   endfunction

   // Narrow ranges make ties and duplicate ids common.
   function automatic logic [ID_W-1:0] pick_id(input int mode);
      if (mode == 0) begin
         return $urandom;
      end else if (mode == 1) begin
         return $urandom_range(0, 7);
      end
      return 32'hFFFF_FFF8 | $urandom_range(0, 7);
   endfunction

   function automatic logic signed [SCORE_W-1:0] pick_score(input int mode);
      if (mode == 0) begin
         return $urandom;
      end else if (mode == 1) begin
         return $signed($urandom_range(0, 8)) - 4;
      end
      case ($urandom_range(0, 4))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return -1;
         3:       return 0;
         default: return 1;
      endcase
   endfunction

   // Lowers valid and holds off until every expected result beat has been taken.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_best.size() != 0);
   endtask

   task automatic set_config(input logic [COUNT_W-1:0] keep, input logic higher);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= REG_KEEP_COUNT;
      csr_wdata <= keep;
      @(posedge clock);
      csr_index <= REG_HIGHER_WINS;
      csr_wdata <= COUNT_W'(higher);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_keep   = keep;
      cfg_higher = higher;
   endtask

   // Offers one candidate beat, waits for acceptance, then records what it should cause.
   task automatic drive_beat(input logic [ID_W-1:0] id,
                             input logic signed [SCORE_W-1:0] score,
                             input logic qend,
                             input check_kind_type check,
                             input logic [ID_W-1:0] exp_id,
                             input logic signed [SCORE_W-1:0] exp_score);
      int gap;
      gap = calm_sender ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cand_id    <= id;
      req_cand_score <= score;
      req_query_end  <= qend;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      rank_candidate(id, score, qend);
      case (check)
         CHECK_PREDICT: begin
            pending_best = {pending_best, fresh_run};
         end
         CHECK_SINGLE: begin
            pending_best = {pending_best, best_entry_type'{exp_id, exp_score, 1'b1}};
         end
         default: begin
         end
      endcase
   endtask

   // Result side: random stalls with occasional long stretches of steady acceptance.
   initial begin
      int hold;
      int calm;
      hold = 0;
      calm = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (calm > 0) begin
            calm--;
            rsp_ready <= 1'b1;
         end else if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 99) == 0) begin
               calm = $urandom_range(50, 200);
            end else begin
               hold = pick_gap();
            end
         end
      end
   end

   // Scoreboard: every result beat against the oldest expectation.
   always @(posedge clock) begin : check_results
      best_entry_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_best.size() == 0) begin
            report_mismatch($sformatf("unexpected result beat id=%h score=%0d",
                                      rsp_best_id, rsp_best_score));
         end else begin
            want = pending_best.pop_front();
            if (rsp_best_id !== want.id) begin
               report_mismatch($sformatf("best_id %h, expected %h", rsp_best_id, want.id));
            end
            if (rsp_best_score !== want.score) begin
               report_mismatch($sformatf("best_score %0d, expected %0d",
                                         rsp_best_score, want.score));
            end
            if (rsp_run_last !== want.run_end) begin
               report_mismatch($sformatf("run_last %b, expected %b",
                                         rsp_run_last, want.run_end));
            end
         end
      end
   end

   // Stimulus: reset, directed table, then random phases of queries.
   initial begin
      int  eff;
      int  n_queries;
      int  len;
      int  id_mode;
      int  score_mode;
      bit  query_open;
      bit  leave_open;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_cand_id    <= '0;
      req_cand_score <= '0;
      req_query_end  <= 1'b0;
      csr_wr_en      <= 1'b0;
      csr_index      <= REG_KEEP_COUNT;
      csr_wdata      <= '0;
      sel_fill   = 0;
      cfg_keep   = COUNT_W'(16);
      cfg_higher = 1'b0;
      query_open = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_PLAN[r]) begin
         if (DIRECTED_PLAN[r].set_cfg) begin
            set_config(DIRECTED_PLAN[r].keep, DIRECTED_PLAN[r].higher);
         end
         drive_beat(DIRECTED_PLAN[r].id, DIRECTED_PLAN[r].score, DIRECTED_PLAN[r].qend,
                    DIRECTED_PLAN[r].check, DIRECTED_PLAN[r].exp_id,
                    DIRECTED_PLAN[r].exp_score);
      end

      while (items_sent < ITEM_TARGET) begin
         // An open query only ever sees its count lowered, never the direction changed.
         eff = (int'(cfg_keep) > MAX_KEEP) ? MAX_KEEP : int'(cfg_keep);
         if (query_open) begin
            set_config(COUNT_W'($urandom_range(0, eff - 1)), cfg_higher);
         end else begin
            set_config(pick_keep(), 1'($urandom_range(0, 1)));
         end
         query_open  = 1'b0;
         calm_sender = ($urandom_range(0, 3) == 0);
         eff = (int'(cfg_keep) > MAX_KEEP) ? MAX_KEEP : int'(cfg_keep);
         n_queries = $urandom_range(2, 6);
         for (int q = 0; q < n_queries; q++) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
            leave_open = (q == n_queries - 1) && (eff > 1) && ($urandom_range(0, 4) == 0);
            id_mode    = $urandom_range(0, 2);
            score_mode = $urandom_range(0, 2);
            for (int b = 0; b < len; b++) begin
               drive_beat(pick_id(id_mode), pick_score(score_mode),
                          (b == len - 1) && !leave_open, CHECK_PREDICT, '0, '0);
            end
            if (leave_open) begin
               query_open = 1'b1;
            end else if ($urandom_range(0, 5) == 0) begin
               wait_drained();
            end
         end
      end

      // Close any query still open so its run is checked too.
      if (query_open) begin
         drive_beat(pick_id(0), pick_score(0), 1'b1, CHECK_PREDICT, '0, '0);
      end
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog far beyond the slowest legal run.
   initial begin
      #5ms;
      $display("FAIL");
      $finish;
   end

endmodule

// File: top_k_score_selector_top.f
hw/rtl/tksel_pkg.sv
hw/rtl/tksel_cell.sv
hw/rtl/tksel_drain_cell.sv
hw/rtl/top_k_score_selector_top.sv
hw/rtl/tksel_checker.sv
tb/tb_top_k_score_selector_top.sv
